// ===== hw/rtl/eia_pkg.sv =====
// eia_pkg: shared types and constants for the entity id allocator.
// Holds op, status and sequencer codes and the live map request bundle.
// No dependencies.
package eia_pkg;

   localparam int ID_SPACE = 256;
   localparam int ID_W     = 8;
   localparam int FREE_CW  = 9;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_FIND   = 3'd1,
      OP_REMOVE = 3'd2,
      OP_FLUSH  = 3'd3,
      OP_RESET  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE      = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_PEND_FULL = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic            clear;
      logic            rd_en;
      logic [ID_W-1:0] rd_addr;
      logic            wr_en;
      logic [ID_W-1:0] wr_addr;
      logic            wr_data;
   } live_req_type;

endpackage

// ===== hw/rtl/eia_ram.sv =====
// eia_ram: generic single-write, single-read RAM with registered read.
// Read data updates only on a read enable. No dependencies.
module eia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/eia_live.sv =====
// eia_live: live map, one bit per id, in RAM with a cleared valid bit per entry.
// Depends on eia_pkg and eia_ram.
module eia_live (
   input  logic                 clock,
   input  logic                 reset,
   input  eia_pkg::live_req_type req,
   output logic                 live
);

   logic [eia_pkg::ID_SPACE-1:0] valid_ff;
   logic                         rd_valid_ff;
   logic                         ram_q;

   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (req.rd_en) begin
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   eia_ram #(
      .WIDTH(1),
      .DEPTH(eia_pkg::ID_SPACE)
   ) u_ram (
      .clock  (clock),
      .wr_en  (req.wr_en),
      .wr_addr(req.wr_addr),
      .wr_data(req.wr_data),
      .rd_en  (req.rd_en),
      .rd_addr(req.rd_addr),
      .rd_data(ram_q)
   );

   assign live = rd_valid_ff & ram_q;

endmodule

// ===== hw/rtl/entity_id_allocator.sv =====
// entity_id_allocator: top level, sequencer, counters and output register.
// Depends on eia_pkg, eia_ram and eia_live.
//
// Allocates 8-bit ids (0 is invalid): create pops the free stack or takes a fresh
// id, find checks the live map, remove parks a live id on the pending list, flush
// pushes every pending id onto the free stack and emits one beat per id, the last
// one flagged. Create, find, remove, reset and an empty flush each have a read step,
// which reads the live map, free stack and pending list RAMs, and an execute step
// that acts on the registered read data. A flush does one pending list read per id.
// The block takes no new beat until the current one's final result is in the
// output register; a result waiting there does not block the next request.
module entity_id_allocator #(
   parameter int PENDING_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_id_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_id_out,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   localparam int PCW = $clog2(PENDING_DEPTH + 1);
   localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int IDW = eia_pkg::ID_W;
   localparam int FCW = eia_pkg::FREE_CW;

   eia_pkg::state_type  state_ff, state_in;
   eia_pkg::op_type     op_ff, op_in;
   logic [IDW-1:0]      id_ff, id_in;
   logic [PCW-1:0]      idx_ff, idx_in;
   logic [IDW-1:0]      fresh_ff, fresh_in;
   logic [FCW-1:0]      free_count_ff, free_count_in;
   logic [PCW-1:0]      pend_count_ff, pend_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDW-1:0]      rsp_id_ff, rsp_id_in;
   eia_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   eia_pkg::live_req_type live_req;
   logic                  live_q;

   logic                free_wr_en, free_rd_en;
   logic [IDW-1:0]      free_wr_addr, free_rd_addr, free_wr_data, free_q;
   logic                pend_wr_en, pend_rd_en;
   logic [PAW-1:0]      pend_wr_addr, pend_rd_addr;
   logic [IDW-1:0]      pend_wr_data, pend_q;

   logic                out_free;
   logic                is_last;
   logic                found;
   logic [PCW-1:0]      idx_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_next = PCW'(idx_ff + PCW'(1));
   assign is_last  = (idx_next == pend_count_ff);
   assign found    = live_q && (id_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= eia_pkg::S_IDLE;
         fresh_ff      <= '0;
         free_count_ff <= '0;
         pend_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fresh_ff      <= fresh_in;
         free_count_ff <= free_count_in;
         pend_count_ff <= pend_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      idx_ff        <= idx_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      idx_in        = idx_ff;
      fresh_in      = fresh_ff;
      free_count_in = free_count_ff;
      pend_count_in = pend_count_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      live_req      = '0;
      free_wr_en    = 1'b0;
      free_wr_addr  = free_count_ff[IDW-1:0];
      free_wr_data  = pend_q;
      free_rd_en    = 1'b0;
      free_rd_addr  = IDW'(free_count_ff - FCW'(1));
      pend_wr_en    = 1'b0;
      pend_wr_addr  = pend_count_ff[PAW-1:0];
      pend_wr_data  = id_ff;
      pend_rd_en    = 1'b0;
      pend_rd_addr  = idx_next[PAW-1:0];

      unique case (state_ff)
         eia_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in            = eia_pkg::op_type'(req_op);
               id_in            = req_id_in;
               idx_in           = '0;
               live_req.rd_en   = 1'b1;
               live_req.rd_addr = req_id_in;
               free_rd_en       = 1'b1;
               pend_rd_en       = 1'b1;
               pend_rd_addr     = '0;
               state_in         = eia_pkg::S_EXEC;
            end
         end
         eia_pkg::S_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_status_in = eia_pkg::ST_NONE;
               rsp_last_in   = 1'b1;
               state_in      = eia_pkg::S_IDLE;
               unique case (op_ff)
                  eia_pkg::OP_CREATE: begin
                     if (free_count_ff != '0) begin
                        free_count_in    = FCW'(free_count_ff - FCW'(1));
                        rsp_id_in        = free_q;
                        rsp_status_in    = eia_pkg::ST_OK;
                        live_req.wr_en   = 1'b1;
                        live_req.wr_addr = free_q;
                        live_req.wr_data = 1'b1;
                     end else if (fresh_ff != IDW'(eia_pkg::ID_SPACE - 1)) begin
                        fresh_in         = IDW'(fresh_ff + IDW'(1));
                        rsp_id_in        = fresh_in;
                        rsp_status_in    = eia_pkg::ST_OK;
                        live_req.wr_en   = 1'b1;
                        live_req.wr_addr = fresh_in;
                        live_req.wr_data = 1'b1;
                     end else begin
                        rsp_status_in = eia_pkg::ST_EXHAUSTED;
                     end
                  end
                  eia_pkg::OP_FIND: begin
                     if (found) begin
                        rsp_id_in     = id_ff;
                        rsp_status_in = eia_pkg::ST_OK;
                     end
                  end
                  eia_pkg::OP_REMOVE: begin
                     if (!found) begin
                        rsp_status_in = eia_pkg::ST_NONE;
                     end else if (pend_count_ff >= PCW'(PENDING_DEPTH)) begin
                        rsp_status_in = eia_pkg::ST_PEND_FULL;
                     end else begin
                        pend_wr_en       = 1'b1;
                        pend_count_in    = PCW'(pend_count_ff + PCW'(1));
                        live_req.wr_en   = 1'b1;
                        live_req.wr_addr = id_ff;
                        live_req.wr_data = 1'b0;
                        rsp_id_in        = id_ff;
                        rsp_status_in    = eia_pkg::ST_OK;
                     end
                  end
                  eia_pkg::OP_FLUSH: begin
                     if (pend_count_ff == '0) begin
                        rsp_status_in = eia_pkg::ST_NONE;
                     end else begin
                        rsp_id_in     = pend_q;
                        rsp_status_in = eia_pkg::ST_OK;
                        rsp_last_in   = is_last;
                        if (free_count_ff < FCW'(eia_pkg::ID_SPACE)) begin
                           free_wr_en    = 1'b1;
                           free_count_in = FCW'(free_count_ff + FCW'(1));
                        end
                        idx_in     = idx_next;
                        pend_rd_en = 1'b1;
                        if (is_last) begin
                           pend_count_in = '0;
                        end else begin
                           state_in = eia_pkg::S_EXEC;
                        end
                     end
                  end
                  eia_pkg::OP_RESET: begin
                     fresh_in       = '0;
                     free_count_in  = '0;
                     pend_count_in  = '0;
                     live_req.clear = 1'b1;
                     rsp_status_in  = eia_pkg::ST_OK;
                  end
                  default: begin
                     rsp_status_in = eia_pkg::ST_NONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = eia_pkg::S_IDLE;
         end
      endcase
   end

   eia_live u_live (
      .clock(clock),
      .reset(reset),
      .req  (live_req),
      .live (live_q)
   );

   eia_ram #(
      .WIDTH(IDW),
      .DEPTH(eia_pkg::ID_SPACE)
   ) u_free_stack (
      .clock  (clock),
      .wr_en  (free_wr_en),
      .wr_addr(free_wr_addr),
      .wr_data(free_wr_data),
      .rd_en  (free_rd_en),
      .rd_addr(free_rd_addr),
      .rd_data(free_q)
   );

   eia_ram #(
      .WIDTH(IDW),
      .DEPTH(PENDING_DEPTH)
   ) u_pending (
      .clock  (clock),
      .wr_en  (pend_wr_en),
      .wr_addr(pend_wr_addr),
      .wr_data(pend_wr_data),
      .rd_en  (pend_rd_en),
      .rd_addr(pend_rd_addr),
      .rd_data(pend_q)
   );

   assign req_stall  = (state_ff != eia_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_id_out = rsp_id_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // every id parked or recycled was once handed out fresh; counts settle between beats
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == eia_pkg::S_IDLE)
         |-> ((10'(free_count_ff) + 10'(pend_count_ff)) <= 10'(fresh_ff)))
      else $error("free and pending ids exceed ids handed out");

   a_pend_bound : assert property (@(posedge clock) disable iff (reset)
      pend_count_ff <= PCW'(PENDING_DEPTH))
      else $error("pending count beyond depth");

   a_pend_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == eia_pkg::ST_PEND_FULL)
         |-> (pend_count_ff == PCW'(PENDING_DEPTH)))
      else $error("pending full reported with room left");

   a_flush_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == eia_pkg::S_EXEC && op_ff == eia_pkg::OP_FLUSH && out_free
         && pend_count_ff != '0 && is_last) |=> (pend_count_ff == '0))
      else $error("pending list not emptied after final flush beat");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for entity_id_allocator (create, find, remove, flush, reset).
// Beats are checked against an in-bench allocator mirror kept in step on each accepted request.
// Depends on eia_pkg and entity_id_allocator.
module tb;

   localparam int PEND_DEPTH  = 32;
   localparam int QUIET_LIMIT = 4000;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [7:0]          id;
      eia_pkg::status_type status;
      logic                last;
   } beat_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] id;
      logic       typed;
      beat_type   exp;
   } row_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic [2:0] req_op    = 3'd0;
   logic [7:0] req_id_in = 8'd0;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_id_out;
   logic [1:0] rsp_status;
   logic       rsp_last;

   // allocator mirror
   logic [7:0] fresh_hi;
   logic       live_q[256];
   logic [7:0] free_stk[$];
   logic [7:0] parked[$];
   logic [7:0] last_gone;

   beat_type beats_due[$];
   logic     row_typed = 1'b0;
   beat_type row_exp   = '0;
   int       faults    = 0;
   int       quiet     = 0;
   int       burst_left = 0;
   bit       eager     = 1'b0;

   entity_id_allocator #(.PENDING_DEPTH(PEND_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_id_in (req_id_in),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_id_out(rsp_id_out),
      .rsp_status(rsp_status),
      .rsp_last  (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_fault(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      faults++;
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         flag_fault($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   function automatic void mirror_clear();
      fresh_hi  = 8'd0;
      last_gone = 8'd0;
      foreach (live_q[i]) live_q[i] = 1'b0;
      free_stk.delete();
      parked.delete();
   endfunction

   function automatic void due(logic [7:0] id, eia_pkg::status_type st, logic lst);
      beat_type b;
      b         = '{id, st, lst};
      beats_due = {beats_due, b};
   endfunction

   function automatic void predict_beats(logic [2:0] op, logic [7:0] id);
      logic [7:0] got;
      case (op)
         eia_pkg::OP_CREATE: begin
            got = 8'd0;
            if (free_stk.size() != 0) begin
               got = free_stk.pop_back();
            end else if (fresh_hi != 8'hFF) begin
               fresh_hi++;
               got = fresh_hi;
            end
            if (got == 8'd0) begin
               due(8'd0, eia_pkg::ST_EXHAUSTED, 1'b1);
            end else begin
               live_q[got] = 1'b1;
               due(got, eia_pkg::ST_OK, 1'b1);
            end
         end
         eia_pkg::OP_FIND: begin
            if (id != 8'd0 && live_q[id]) due(id, eia_pkg::ST_OK, 1'b1);
            else due(8'd0, eia_pkg::ST_NONE, 1'b1);
         end
         eia_pkg::OP_REMOVE: begin
            if (id == 8'd0 || !live_q[id]) begin
               due(8'd0, eia_pkg::ST_NONE, 1'b1);
            end else if (parked.size() >= PEND_DEPTH) begin
               due(8'd0, eia_pkg::ST_PEND_FULL, 1'b1);
            end else begin
               parked     = {parked, id};
               live_q[id] = 1'b0;
               last_gone  = id;
               due(id, eia_pkg::ST_OK, 1'b1);
            end
         end
         eia_pkg::OP_FLUSH: begin
            if (parked.size() == 0) begin
               due(8'd0, eia_pkg::ST_NONE, 1'b1);
            end else begin
               foreach (parked[i]) begin
                  free_stk = {free_stk, parked[i]};
                  due(parked[i], eia_pkg::ST_OK, i == parked.size() - 1);
               end
               parked.delete();
            end
         end
         eia_pkg::OP_RESET: begin
            mirror_clear();
            due(8'd0, eia_pkg::ST_OK, 1'b1);
         end
         default: due(8'd0, eia_pkg::ST_NONE, 1'b1);
      endcase
   endfunction

   function automatic logic [7:0] pick_live();
      int n;
      int k;
      n = 0;
      foreach (live_q[i]) if (live_q[i]) n++;
      if (n == 0) return 8'($urandom);
      k = $urandom_range(0, n - 1);
      foreach (live_q[i]) begin
         if (live_q[i]) begin
            if (k == 0) return 8'(i);
            k--;
         end
      end
      return 8'd0;
   endfunction

   function automatic logic [2:0] pick_op(int kind);
      int c[5];
      int r;
      case (kind)
         0:       c = '{30, 50, 75, 90, 93};
         1:       c = '{60, 75, 90, 95, 95};
         2:       c = '{25, 35, 95, 95, 95};
         default: c = '{35, 40, 70, 95, 97};
      endcase
      r = $urandom_range(0, 99);
      if (r < c[0]) return eia_pkg::OP_CREATE;
      if (r < c[1]) return eia_pkg::OP_FIND;
      if (r < c[2]) return eia_pkg::OP_REMOVE;
      if (r < c[3]) return eia_pkg::OP_FLUSH;
      if (r < c[4]) return eia_pkg::OP_RESET;
      return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
   endfunction

   function automatic logic [7:0] pick_id(logic [2:0] op);
      int r;
      if (op != eia_pkg::OP_FIND && op != eia_pkg::OP_REMOVE) return 8'($urandom);
      r = $urandom_range(0, 9);
      if (r < 6) return pick_live();
      if (r == 6) return last_gone;
      if (r == 7) return 8'd0;
      if (r == 8) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Moves to the next falling edge, with a random gap between bursts. Valid is low on return.
   task automatic take_turn();
      @(negedge clock);
      req_valid = 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!eager && $urandom_range(0, 3) != 0) begin
            req_op    = 3'($urandom);
            req_id_in = 8'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_beat(logic [2:0] op, logic [7:0] id, logic typed, beat_type exp);
      req_valid = 1'b1;
      req_op    = op;
      req_id_in = id;
      row_typed = typed;
      row_exp   = exp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Results checked first: a beat accepted here always belongs to an earlier request.
   always @(posedge clock) begin : monitor
      beat_type want;
      int       n0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               flag_fault($sformatf("unexpected beat id %0d status %0d last %0d",
                                    rsp_id_out, rsp_status, rsp_last));
            end else begin
               want = beats_due.pop_front();
               compare_field("id_out", rsp_id_out, want.id);
               compare_field("status", 8'(rsp_status), 8'(want.status));
               compare_field("last", 8'(rsp_last), 8'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            n0 = beats_due.size();
            predict_beats(req_op, req_id_in);
            if (row_typed) begin
               while (beats_due.size() > n0) void'(beats_due.pop_back());
               beats_due = {beats_due, row_exp};
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   initial begin : rsp_side
      int          mode;
      logic [15:0] pat;
      forever begin
         mode   = $urandom_range(0, 3);
         pat    = 16'($urandom);
         pat[0] = 1'b0;
         repeat ($urandom_range(40, 200)) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 3) == 0);
               2:       rsp_stall = ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_stall = pat[0];
                  pat       = {pat[0], pat[15:1]};
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      row_type    plan[23];
      logic [2:0] op;
      logic [7:0] id;
      plan = '{
         '{eia_pkg::OP_FIND,   8'd0,  1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_FIND,   8'hFF, 1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_REMOVE, 8'hFF, 1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_FLUSH,  8'hFF, 1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{OP_SPARE_LO,        8'd0,  1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{OP_SPARE_HI,        8'hFF, 1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_CREATE, 8'hAA, 1'b1, '{8'd1, eia_pkg::ST_OK,   1'b1}},
         '{eia_pkg::OP_CREATE, 8'h55, 1'b1, '{8'd2, eia_pkg::ST_OK,   1'b1}},
         '{eia_pkg::OP_CREATE, 8'd0,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_FIND,   8'd1,  1'b1, '{8'd1, eia_pkg::ST_OK,   1'b1}},
         '{eia_pkg::OP_REMOVE, 8'd1,  1'b1, '{8'd1, eia_pkg::ST_OK,   1'b1}},
         '{eia_pkg::OP_REMOVE, 8'd1,  1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_FIND,   8'd1,  1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_REMOVE, 8'd3,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_REMOVE, 8'd2,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_FLUSH,  8'd0,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_CREATE, 8'd0,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_CREATE, 8'd0,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_FIND,   8'd2,  1'b0, '{8'd0, eia_pkg::ST_OK,   1'b0}},
         '{eia_pkg::OP_RESET,  8'hFF, 1'b1, '{8'd0, eia_pkg::ST_OK,   1'b1}},
         '{eia_pkg::OP_FIND,   8'd2,  1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}},
         '{eia_pkg::OP_CREATE, 8'd0,  1'b1, '{8'd1, eia_pkg::ST_OK,   1'b1}},
         '{eia_pkg::OP_FLUSH,  8'd0,  1'b1, '{8'd0, eia_pkg::ST_NONE, 1'b1}}
      };
      mirror_clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         take_turn();
         send_beat(plan[i].op, plan[i].id, plan[i].typed, plan[i].exp);
      end

      for (int ph = 0; ph < 2; ph++) begin
         eager = ($urandom_range(0, 2) == 0);
         if (ph == 0) begin
            // run the id space dry, then overfill the pending list
            take_turn();
            send_beat(eia_pkg::OP_FLUSH, 8'($urandom), 1'b0, '0);
            forever begin
               take_turn();
               if (free_stk.size() == 0 && fresh_hi == 8'hFF) break;
               send_beat(eia_pkg::OP_CREATE, 8'($urandom), 1'b0, '0);
            end
            send_beat(eia_pkg::OP_CREATE, 8'($urandom), 1'b0, '0);
            repeat (PEND_DEPTH + 1) begin
               take_turn();
               send_beat(eia_pkg::OP_REMOVE, pick_live(), 1'b0, '0);
            end
            take_turn();
            send_beat(eia_pkg::OP_FLUSH, 8'($urandom), 1'b0, '0);
         end
         repeat (8) begin
            take_turn();
            op = pick_op(ph % 4);
            id = pick_id(op);
            send_beat(op, id, 1'b0, '0);
         end
      end

      take_turn();
      while (beats_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (faults == 0 && beats_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
